/* src/u2u_pkg.sv */
`default_nettype none

package u2u_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [15:0] MAX_UNITS_RST = 16'hFFFF;
    localparam logic [20:0] SUPP_OFFSET   = 21'h10000;
    localparam logic [15:0] SURR_HIGH     = 16'hD800;
    localparam logic [15:0] SURR_LOW      = 16'hDC00;

    // register indexes on the configuration port
    localparam logic REG_MAX_UNITS = 1'b0;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TRUNC   = 2'd1,
        ST_INVALID = 2'd2,
        ST_LIMIT   = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic [1:0]  status;
        logic        run_end;
        logic        string_end;
    } t_out_item;

    // one decoded byte: up to two units, or a status-only end of string
    typedef struct packed {
        logic [15:0] unit0;
        logic [15:0] unit1;
        logic        has_unit;
        logic        two_units;
        t_status     status;
        logic        last;
    } t_qentry;

endpackage

`default_nettype wire

/* src/u2u_front.sv */
`default_nettype none

module u2u_front
    import u2u_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire t_in_item    i_item,
    input  wire logic [15:0] i_max_units,
    output logic             o_push,
    output t_qentry          o_entry
);

    logic [1:0]  r_pending, n_pending;
    logic [1:0]  r_seq_len, n_seq_len;
    logic [20:0] r_accum,   n_accum;
    logic [15:0] r_units,   n_units;
    logic        r_halted,  n_halted;
    t_status     r_halt_st, n_halt_st;

    logic [1:0]  nu;
    logic [15:0] u0, u1;
    logic [20:0] cp;
    logic [7:0]  b;

    assign b = i_item.in_byte;

    always_comb begin
        n_pending = r_pending;
        n_seq_len = r_seq_len;
        n_accum   = r_accum;
        n_units   = r_units;
        n_halted  = r_halted;
        n_halt_st = r_halt_st;
        nu        = 2'd0;
        u0        = '0;
        u1        = '0;
        cp        = '0;

        if (!r_halted) begin
            if (r_pending != 2'd0) begin
                n_accum   = {r_accum[14:0], b[5:0]};
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    if (r_seq_len == 2'd3) begin
                        cp = n_accum - SUPP_OFFSET;
                        u0 = SURR_HIGH | {6'b0, cp[19:10]};
                        u1 = SURR_LOW  | {6'b0, cp[9:0]};
                        nu = 2'd2;
                    end else begin
                        u0 = n_accum[15:0];
                        nu = 2'd1;
                    end
                end
            end else if (r_units >= i_max_units) begin
                n_halted  = 1'b1;
                n_halt_st = ST_LIMIT;
                n_pending = 2'd0;
            end else if (!b[7]) begin
                u0 = {8'h00, b};
                nu = 2'd1;
            end else if (b[7:5] == 3'b110) begin
                n_accum   = {16'b0, b[4:0]};
                n_pending = 2'd1;
                n_seq_len = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                n_accum   = {17'b0, b[3:0]};
                n_pending = 2'd2;
                n_seq_len = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                n_accum   = {18'b0, b[2:0]};
                n_pending = 2'd3;
                n_seq_len = 2'd3;
            end else begin
                n_halted  = 1'b1;
                n_halt_st = ST_INVALID;
                n_pending = 2'd0;
            end

            // a unit or pair that would pass the limit is dropped whole
            if (nu != 2'd0) begin
                if (({1'b0, r_units} + {15'b0, nu}) > {1'b0, i_max_units}) begin
                    nu        = 2'd0;
                    n_halted  = 1'b1;
                    n_halt_st = ST_LIMIT;
                    n_pending = 2'd0;
                end else begin
                    n_units = r_units + {14'b0, nu};
                end
            end
        end

        o_entry.unit0     = u0;
        o_entry.unit1     = u1;
        o_entry.has_unit  = (nu != 2'd0);
        o_entry.two_units = (nu == 2'd2);
        o_entry.last      = i_item.last_byte;
        if (nu != 2'd0) begin
            o_entry.status = ST_OK;
        end else if (n_halted) begin
            o_entry.status = n_halt_st;
        end else if (n_pending != 2'd0) begin
            o_entry.status = ST_TRUNC;
        end else begin
            o_entry.status = ST_OK;
        end

        o_push = i_accept && ((nu != 2'd0) || i_item.last_byte);

        if (i_item.last_byte) begin
            n_pending = 2'd0;
            n_seq_len = 2'd0;
            n_accum   = '0;
            n_units   = '0;
            n_halted  = 1'b0;
            n_halt_st = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_seq_len <= 2'd0;
            r_accum   <= '0;
            r_units   <= '0;
            r_halted  <= 1'b0;
            r_halt_st <= ST_OK;
        end else if (i_accept) begin
            r_pending <= n_pending;
            r_seq_len <= n_seq_len;
            r_accum   <= n_accum;
            r_units   <= n_units;
            r_halted  <= n_halted;
            r_halt_st <= n_halt_st;
        end
    end

endmodule

`default_nettype wire

/* src/u2u_queue.sv */
`default_nettype none

module u2u_queue
    import u2u_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_qentry i_entry,
    output logic         o_full,
    input  wire logic    i_pop,
    output t_qentry      o_head,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_qentry       r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* src/u2u_back.sv */
`default_nettype none

module u2u_back
    import u2u_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_qentry i_head,
    input  wire logic    i_q_empty,
    output logic         o_q_pop,
    input  wire logic    i_pop,
    output logic         o_empty,
    output t_out_item    o_item
);

    logic      r_out_valid;
    logic      r_half;
    t_out_item r_out, n_out;
    logic      load, take, is_pair;

    assign load    = !r_out_valid || i_pop;
    assign take    = load && !i_q_empty;
    assign is_pair = i_head.has_unit && i_head.two_units;
    assign o_q_pop = take && (!is_pair || r_half);
    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    always_comb begin
        if (!i_head.has_unit) begin
            n_out.code_unit  = '0;
            n_out.unit_valid = 1'b0;
            n_out.status     = i_head.status;
            n_out.run_end    = 1'b1;
            n_out.string_end = 1'b1;
        end else if (r_half) begin
            n_out.code_unit  = i_head.unit1;
            n_out.unit_valid = 1'b1;
            n_out.status     = ST_OK;
            n_out.run_end    = 1'b1;
            n_out.string_end = i_head.last;
        end else begin
            n_out.code_unit  = i_head.unit0;
            n_out.unit_valid = 1'b1;
            n_out.status     = ST_OK;
            n_out.run_end    = !i_head.two_units;
            n_out.string_end = i_head.last && !i_head.two_units;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_half      <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= !i_q_empty;
            end
            if (take) begin
                r_half <= is_pair && !r_half;
            end
        end
    end

endmodule

`default_nettype wire

/* src/utf8_to_utf16_stream_decoder.sv */
// path: an accepted byte is decoded combinationally, written into the queue, then loaded into the result register
// throughput: one byte per cycle on the input while full is low; one result per cycle on the output
//   while pop is held, so a surrogate pair takes two results and the queue absorbs it
// reset: synchronous, active low; clears decode state, empties the queue and the result register,
//   and sets max_units to 65535
`default_nettype none

module utf8_to_utf16_stream_decoder
    import u2u_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input, queue style
    input  wire logic        push,
    output logic             full,
    input  wire t_in_item    i_in_item,
    // result output, queue style
    output logic             empty,
    input  wire logic        pop,
    output t_out_item        o_out_item,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0] r_max_units;
    logic        cfg_write;
    logic        accept;
    logic        q_push, q_pop, q_full, q_empty;
    t_qentry     q_entry, q_head;

    // register index is the word address; only max_units exists
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_units <= MAX_UNITS_RST;
        end else if (cfg_write && (paddr[2] == REG_MAX_UNITS)) begin
            r_max_units <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAX_UNITS) ? {16'b0, r_max_units} : '0;

    // a byte is taken whenever the queue has room, even while a result waits
    assign full   = q_full;
    assign accept = push && !q_full;

    // front: per-byte decode, string state, limit and status checks
    u2u_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .i_max_units (r_max_units),
        .o_push      (q_push),
        .o_entry     (q_entry)
    );

    // short queue of decoded requests between front and back
    u2u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    // back: splits surrogate pairs into single results, holds the result register
    u2u_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_out_item)
    );

endmodule

`default_nettype wire

/* src/u2u_checker.sv */
`default_nettype none

module u2u_checker
    import u2u_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      empty,
    input wire logic      pop,
    input wire t_out_item o_out_item
);

    // nothing to deliver right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("result changed while stalled");

    // status-only result always closes a string with a failure status
    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_item.unit_valid) |->
        (o_out_item.string_end && o_out_item.run_end && (o_out_item.status != ST_OK)))
        else $error("bad status-only result");

    // second half of a pair follows the first at once
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_out_item.run_end) |=> (!empty && o_out_item.unit_valid))
        else $error("low surrogate missing");

endmodule

bind utf8_to_utf16_stream_decoder u2u_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .empty      (empty),
    .pop        (pop),
    .o_out_item (o_out_item)
);

`default_nettype wire

/* dv/tb_utf8_to_utf16_stream_decoder.sv */
`default_nettype none

module tb_utf8_to_utf16_stream_decoder;
    import u2u_pkg::*;

    // run length guard, well above the slowest legal run
    localparam int LIMIT_CYCLES = 1_000_000;
    // cycles to let a byte with no result work through before a register write
    localparam int SETTLE_CYCLES = 4;
    localparam logic [2:0] MAX_UNITS_ADDR = {REG_MAX_UNITS, 2'b00};

    typedef logic [7:0] t_byte_q[$];

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // byte requests into the decoder
    logic     push = 1'b0;
    logic     full;
    t_in_item i_in_item = '0;

    // code unit requests out of the decoder
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_out_item;

    // register port
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    utf8_to_utf16_stream_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    // decoder shadow state, mirrors what the block holds per string
    logic [1:0]  dec_pending;
    logic [1:0]  dec_seqlen;
    logic [20:0] dec_accum;
    int unsigned dec_units;
    logic        dec_halted;
    t_status     dec_halt_st;
    logic [15:0] cfg_max_units = MAX_UNITS_RST;

    // code units and status results still owed by the block, oldest first
    t_out_item exp_units[$];
    t_byte_q   str_buf;

    int mismatches = 0;
    int items_sent = 0;
    int cycle_count = 0;

    // idle mix, percentage chance of a gap after each request
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    int pop_hold = 0;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void clear_decoder();
        dec_pending = '0;
        dec_seqlen  = '0;
        dec_accum   = '0;
        dec_units   = 0;
        dec_halted  = 1'b0;
        dec_halt_st = ST_OK;
    endfunction

    function automatic void halt_decoder(input t_status why);
        dec_halted  = 1'b1;
        dec_halt_st = why;
        dec_pending = '0;
    endfunction

    // work out the code units (and final status) that one byte yields
    function automatic void predict_byte(input t_in_item it);
        logic [7:0]  b;
        logic [15:0] unit_a;
        logic [15:0] unit_b;
        logic [20:0] offs;
        int unsigned nu;
        t_status     fin_st;
        t_out_item   r;
        b = it.in_byte;
        unit_a = '0;
        unit_b = '0;
        nu = 0;
        if (!dec_halted) begin
            if (dec_pending != 0) begin
                // continuation: low six bits only, content never checked
                dec_accum = {dec_accum[14:0], b[5:0]};
                dec_pending = dec_pending - 2'd1;
                if (dec_pending == 0) begin
                    if (dec_seqlen == 2'd3) begin
                        // supplementary plane, offset wraps modulo 2^20
                        offs = dec_accum - SUPP_OFFSET;
                        unit_a = SURR_HIGH | {6'b0, offs[19:10]};
                        unit_b = SURR_LOW | {6'b0, offs[9:0]};
                        nu = 2;
                    end else begin
                        unit_a = dec_accum[15:0];
                        nu = 1;
                    end
                end
            end else if (dec_units >= cfg_max_units) begin
                halt_decoder(ST_LIMIT);
            end else if (b[7] == 1'b0) begin
                unit_a = {8'h00, b};
                nu = 1;
            end else if (b[7:5] == 3'b110) begin
                dec_accum = {16'b0, b[4:0]};
                dec_pending = 2'd1;
                dec_seqlen = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                dec_accum = {17'b0, b[3:0]};
                dec_pending = 2'd2;
                dec_seqlen = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                dec_accum = {18'b0, b[2:0]};
                dec_pending = 2'd3;
                dec_seqlen = 2'd3;
            end else begin
                halt_decoder(ST_INVALID);
            end

            // a completed sequence that would overrun the limit is dropped whole
            if (nu != 0) begin
                if (dec_units + nu > cfg_max_units) begin
                    nu = 0;
                    halt_decoder(ST_LIMIT);
                end else begin
                    dec_units = dec_units + nu;
                end
            end
        end

        for (int i = 0; i < nu; i++) begin
            r.code_unit  = (i == 0) ? unit_a : unit_b;
            r.unit_valid = 1'b1;
            r.status     = ST_OK;
            r.run_end    = (i + 1 == nu);
            r.string_end = it.last_byte && (i + 1 == nu);
            exp_units.insert(exp_units.size(), r);
        end

        if (it.last_byte) begin
            if (nu == 0) begin
                // nothing completed on the last byte: a status-only result
                if (dec_halted)
                    fin_st = dec_halt_st;
                else if (dec_pending != 0)
                    fin_st = ST_TRUNC;
                else
                    fin_st = ST_OK;
                r.code_unit  = '0;
                r.unit_valid = 1'b0;
                r.status     = fin_st;
                r.run_end    = 1'b1;
                r.string_end = 1'b1;
                exp_units.insert(exp_units.size(), r);
            end
            clear_decoder();
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // result side: random stalls on pop, with stretches of none
    always @(posedge i_clk) begin
        if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold--;
        end else if ($urandom_range(0, 99) < rx_stall_pct) begin
            pop <= 1'b0;
            pop_hold = pick_gap() - 1;
        end else begin
            pop <= 1'b1;
        end
    end

    // compare every accepted result with the oldest owed one
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (exp_units.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual unit %h valid %b status %0d",
                         $time, o_out_item.code_unit, o_out_item.unit_valid, o_out_item.status);
                mismatches++;
            end else begin
                want = exp_units.pop_front();
                check_field("code_unit", want.code_unit, o_out_item.code_unit);
                check_field("unit_valid", want.unit_valid, o_out_item.unit_valid);
                check_field("status", want.status, o_out_item.status);
                check_field("run_end", want.run_end, o_out_item.run_end);
                check_field("string_end", want.string_end, o_out_item.string_end);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL utf8_to_utf16_stream_decoder");
            $finish;
        end
    end

    // one byte request, held until accepted, then an optional gap
    task automatic send_byte(input logic [7:0] b, input logic lst);
        t_in_item it;
        it.in_byte = b;
        it.last_byte = lst;
        push <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (full);
        predict_byte(it);
        items_sent++;
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            push <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
    endtask

    // hold off until every owed result is out and the block has settled
    task automatic wait_idle();
        push <= 1'b0;
        while (exp_units.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write max_units on the register port and read it back
    task automatic set_max_units(input logic [15:0] value);
        wait_idle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= MAX_UNITS_ADDR;
        pwdata <= {16'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cfg_max_units = value;
        // read-back follows straight on
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {16'h0, value}) begin
            $display("%0t: max_units read-back mismatch, expected %h, actual %h",
                     $time, {16'h0, value}, prdata);
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // send the buffered string, last flag on its final byte; optionally
    // change the limit part-way through
    task automatic send_buf(input int cfg_at);
        int n;
        n = str_buf.size();
        for (int i = 0; i < n; i++) begin
            if (i == cfg_at)
                set_max_units(16'($urandom_range(0, 6)));
            send_byte(str_buf[i], i == n - 1);
        end
        str_buf.delete();
    endtask

    // well-formed sequences with random payload; noisy strings add stray
    // leads, bad continuations and a cut-off tail
    task automatic build_random_string(input bit noisy, input int max_seqs);
        int nseq;
        int ncont;
        int keep;
        logic [7:0] lead;
        bit cut;
        nseq = $urandom_range(1, max_seqs);
        cut = noisy && ($urandom_range(0, 3) == 0);
        for (int s = 0; s < nseq; s++) begin
            ncont = $urandom_range(0, 3);
            case (ncont)
                0: begin
                    lead = {1'b0, 7'($urandom)};
                end
                1: begin
                    lead = {3'b110, 5'($urandom)};
                end
                2: begin
                    lead = {4'b1110, 4'($urandom)};
                end
                default: begin
                    lead = {5'b11110, 3'($urandom)};
                end
            endcase
            if (noisy && $urandom_range(0, 15) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    str_buf.insert(str_buf.size(), 8'($urandom_range(8'h80, 8'hBF)));
                else
                    str_buf.insert(str_buf.size(), 8'($urandom_range(8'hF8, 8'hFF)));
            end
            str_buf.insert(str_buf.size(), lead);
            keep = ncont;
            if (cut && s == nseq - 1 && ncont > 0)
                keep = $urandom_range(0, ncont - 1);
            for (int c = 0; c < keep; c++) begin
                if (noisy && $urandom_range(0, 7) == 0)
                    str_buf.insert(str_buf.size(), 8'($urandom));
                else
                    str_buf.insert(str_buf.size(), {2'b10, 6'($urandom)});
            end
        end
    endtask

    // plain ascii at both ends of the range
    task automatic test_ascii_extremes();
        str_buf = '{8'h00, 8'h7F};
        send_buf(-1);
    endtask

    // two, three and four byte forms, incl. the top plane and an overlong
    // four byte form whose offset wraps
    task automatic test_multibyte_forms();
        str_buf = '{8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_buf(-1);
        str_buf = '{8'hF0, 8'h80, 8'h80, 8'h80};
        send_buf(-1);
    endtask

    // invalid lead halts the string, later bytes swallowed; cut-off sequence
    task automatic test_invalid_and_truncated();
        str_buf = '{8'h80, 8'h41, 8'hFF};
        send_buf(-1);
        str_buf = '{8'hE2, 8'h82};
        send_buf(-1);
    endtask

    // zero limit, surrogate pair over the limit, lead at the limit
    task automatic test_unit_limits();
        set_max_units(16'd0);
        str_buf = '{8'h41};
        send_buf(-1);
        set_max_units(16'd1);
        str_buf = '{8'hF0, 8'h9F, 8'h98, 8'h80};
        send_buf(-1);
        str_buf = '{8'h41, 8'h42};
        send_buf(-1);
        set_max_units(MAX_UNITS_RST);
    endtask

    // sweep of limits and idle mixes with mostly clean random strings
    task automatic test_random_traffic(input int per_setting);
        int limits[9];
        int tx_mix[4];
        int rx_mix[4];
        int start;
        limits = '{65535, 0, 1, 2, 3, 7, $urandom_range(4, 30), 65534, 65535};
        tx_mix = '{0, 20, 50, 5};
        rx_mix = '{0, 20, 10, 60};
        for (int k = 0; k < 9; k++) begin
            set_max_units(16'(limits[k]));
            tx_gap_pct = tx_mix[k % 4];
            rx_stall_pct = rx_mix[(k + k / 4) % 4];
            start = items_sent;
            while (items_sent - start < per_setting) begin
                build_random_string($urandom_range(0, 4) == 0, 6);
                send_buf(-1);
            end
        end
    endtask

    // limit lowered (or raised) part-way through a string
    task automatic test_limit_change_mid_string(input int count);
        int start;
        tx_gap_pct = 15;
        rx_stall_pct = 15;
        start = items_sent;
        while (items_sent - start < count) begin
            build_random_string($urandom_range(0, 4) == 0, 6);
            if ($urandom_range(0, 2) == 0)
                send_buf($urandom_range(0, str_buf.size() - 1));
            else
                send_buf(-1);
        end
        set_max_units(MAX_UNITS_RST);
    endtask

    // sender holds off after each string until everything owed has come out
    task automatic test_drain_between_strings(input int count);
        int start;
        tx_gap_pct = 10;
        rx_stall_pct = 40;
        start = items_sent;
        while (items_sent - start < count) begin
            build_random_string(1'b1, 4);
            send_buf(-1);
            wait_idle();
        end
    endtask

    initial begin
        cfg_max_units = MAX_UNITS_RST;
        clear_decoder();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ascii_extremes();
        test_multibyte_forms();
        test_invalid_and_truncated();
        test_unit_limits();
        test_random_traffic(90);
        test_limit_change_mid_string(200);
        test_drain_between_strings(140);

        // drain, then keep watching for anything stray
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS utf8_to_utf16_stream_decoder");
        end else begin
            $display("FAIL utf8_to_utf16_stream_decoder");
        end
        $finish;
    end

endmodule

`default_nettype wire
